>>> rtl/core/dfsh_pkg.sv
// Shared types and constants for the depth-first path label histogram core.
// Used by dfsh_ctrl, dfsh_datapath and the top level; depends on nothing else.
`timescale 1ns / 1ps

package dfsh_pkg;

	// Table geometry
	localparam int MAX_VERTICES = 256;
	localparam int MAX_LABELS   = 16;
	localparam int DEPTH_LEVELS = 8;
	localparam int COUNT_BITS   = 16;

	localparam int VID_BITS   = 8;
	localparam int LAB_BITS   = 4;
	localparam int DEP_BITS   = 3;
	localparam int LEVEL_BITS = 4;
	localparam int LIM_BITS   = 4;

	localparam int VD_DEPTH  = MAX_VERTICES * DEPTH_LEVELS;
	localparam int LD_DEPTH  = MAX_LABELS * DEPTH_LEVELS;
	localparam int LP_DEPTH  = MAX_LABELS * MAX_LABELS;
	localparam int LPD_DEPTH = (DEPTH_LEVELS - 1) * MAX_LABELS * MAX_LABELS;

	localparam int VD_AW  = 11;
	localparam int LD_AW  = 7;
	localparam int LP_AW  = 8;
	localparam int LPD_AW = 11;

	// The clearing sweep covers the largest table.
	localparam int SWEEP_BITS = 11;

	localparam logic [LIM_BITS-1:0] PATH_LIMIT_RESET = 4'd4;

	// Command codes
	localparam logic [2:0] CMD_START    = 3'd0;
	localparam logic [2:0] CMD_DISCOVER = 3'd1;
	localparam logic [2:0] CMD_FINISH   = 3'd2;
	localparam logic [2:0] CMD_READ     = 3'd3;
	localparam logic [2:0] CMD_CLEAR    = 3'd4;

	// Table selectors for reads
	localparam logic [1:0] TAB_VERTEX_DEPTH = 2'd0;
	localparam logic [1:0] TAB_LABEL_DEPTH  = 2'd1;
	localparam logic [1:0] TAB_LABEL_PAIR   = 2'd2;
	localparam logic [1:0] TAB_PAIR_DEPTH   = 2'd3;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic finish;
		logic sweep;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;
		logic is_clear;
		logic sweep_last;
	} dp_status_t;

endpackage

>>> rtl/core/dfsh_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; depends on nothing.
`timescale 1ns / 1ps

module dfsh_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/dfsh_ctrl.sv
// Controller state machine: clearing sweep, item accept and execute steps.
// Depends on dfsh_pkg.
`timescale 1ns / 1ps

module dfsh_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  dfsh_pkg::dp_status_t status,
	output dfsh_pkg::ctrl_cmd_t  cmd
);

	dfsh_pkg::state_t state_q, state_d;

	// State register; reset starts a clearing sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dfsh_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dfsh_pkg::ST_CLEAR: begin
				if (status.sweep_last) state_d = dfsh_pkg::ST_IDLE;
			end
			dfsh_pkg::ST_IDLE: begin
				if (in_valid && status.out_free) state_d = dfsh_pkg::ST_EXEC;
			end
			dfsh_pkg::ST_EXEC: begin
				state_d = status.is_clear ? dfsh_pkg::ST_CLEAR : dfsh_pkg::ST_IDLE;
			end
			default: state_d = dfsh_pkg::ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		in_ready   = 1'b0;
		cmd.finish = 1'b0;
		cmd.sweep  = 1'b0;
		unique case (state_q)
			dfsh_pkg::ST_CLEAR: cmd.sweep  = 1'b1;
			dfsh_pkg::ST_IDLE:  in_ready   = status.out_free;
			dfsh_pkg::ST_EXEC:  cmd.finish = 1'b1;
			default: ;
		endcase
		cmd.accept = in_ready & in_valid;
	end

	// An accepted word is always followed by its execute step.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == dfsh_pkg::ST_EXEC)
		else $error("accepted word not executed");

	// Execute lasts exactly one cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> !cmd.finish)
		else $error("execute step repeated");

	// No word is taken while tables are being cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep |-> !in_ready)
		else $error("ready during clearing sweep");

endmodule

>>> rtl/core/dfsh_datapath.sv
// Datapath: label stack, four count memories, saturating update and result word.
// Depends on dfsh_pkg and dfsh_ram.
`timescale 1ns / 1ps

module dfsh_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dfsh_pkg::ctrl_cmd_t  cmd,
	output dfsh_pkg::dp_status_t status,
	input  logic                 cfg_we,
	input  logic [3:0]           cfg_wdata,
	input  logic [31:0]          in_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [23:0]          out_word
);

	localparam int CB = dfsh_pkg::COUNT_BITS;
	localparam logic [CB-1:0] COUNT_TOP = {CB{1'b1}};

	// Input fields
	logic [2:0] f_cmd;
	logic [7:0] f_vid;
	logic [3:0] f_lab;
	logic [1:0] f_tab;
	logic [7:0] f_row;
	logic [3:0] f_col;
	logic [2:0] f_lvl;

	assign f_cmd = in_word[2:0];
	assign f_vid = in_word[10:3];
	assign f_lab = in_word[14:11];
	assign f_tab = in_word[16:15];
	assign f_row = in_word[24:17];
	assign f_col = in_word[28:25];
	assign f_lvl = in_word[31:29];

	logic [dfsh_pkg::LIM_BITS-1:0]   path_limit_q;
	logic [dfsh_pkg::LEVEL_BITS-1:0] level_q;
	logic [dfsh_pkg::LAB_BITS-1:0]   stack_q [dfsh_pkg::DEPTH_LEVELS];
	logic [dfsh_pkg::SWEEP_BITS-1:0] sweep_q;

	logic                 inc_s1, pair_s1, read_s1, err_s1, clr_s1;
	logic [1:0]           tab_s1;
	logic [dfsh_pkg::VD_AW-1:0]  vd_addr_s1;
	logic [dfsh_pkg::LD_AW-1:0]  ld_addr_s1;
	logic [dfsh_pkg::LP_AW-1:0]  lp_addr_s1;
	logic [dfsh_pkg::LPD_AW-1:0] lpd_addr_s1;

	logic                 out_valid_q;
	logic [CB-1:0]        count_q;
	logic                 error_q;

	// Decode of the incoming word
	logic [dfsh_pkg::LIM_BITS-1:0]   lim;
	logic [dfsh_pkg::DEP_BITS-1:0]   d, dm1;
	logic [dfsh_pkg::LAB_BITS-1:0]   prev;
	logic is_start, is_disc, is_fin, is_read, is_clr;
	logic disc_ok, fin_ok, read_ok, err;
	logic [dfsh_pkg::VD_AW-1:0]  vd_ra;
	logic [dfsh_pkg::LD_AW-1:0]  ld_ra;
	logic [dfsh_pkg::LP_AW-1:0]  lp_ra;
	logic [dfsh_pkg::LPD_AW-1:0] lpd_ra;

	always_comb begin
		lim = path_limit_q;
		if (lim == 4'd0) lim = 4'd1;
		if (lim > 4'(dfsh_pkg::DEPTH_LEVELS)) lim = 4'(dfsh_pkg::DEPTH_LEVELS);
		d    = level_q[dfsh_pkg::DEP_BITS-1:0];
		dm1  = d - 3'd1;
		prev = stack_q[dm1];

		is_start = f_cmd == dfsh_pkg::CMD_START;
		is_disc  = f_cmd == dfsh_pkg::CMD_DISCOVER;
		is_fin   = f_cmd == dfsh_pkg::CMD_FINISH;
		is_read  = f_cmd == dfsh_pkg::CMD_READ;
		is_clr   = f_cmd == dfsh_pkg::CMD_CLEAR;

		disc_ok = (level_q != 4'd0) && (level_q < lim);
		fin_ok  = level_q != 4'd0;
		unique case (f_tab)
			dfsh_pkg::TAB_VERTEX_DEPTH: read_ok = !f_col[3];
			dfsh_pkg::TAB_LABEL_DEPTH:  read_ok = (f_row[7:4] == 4'd0) && !f_col[3];
			dfsh_pkg::TAB_LABEL_PAIR:   read_ok = f_row[7:4] == 4'd0;
			dfsh_pkg::TAB_PAIR_DEPTH:   read_ok = (f_row[7:4] == 4'd0) && (f_lvl != 3'd7);
			default:                    read_ok = 1'b0;
		endcase

		err = !(is_start || (is_disc && disc_ok) || (is_fin && fin_ok)
			|| (is_read && read_ok) || is_clr);

		// Read addresses: table lookups for reads, update targets otherwise.
		if (is_read) begin
			vd_ra  = {f_row, f_col[2:0]};
			ld_ra  = {f_row[3:0], f_col[2:0]};
			lp_ra  = {f_row[3:0], f_col};
			lpd_ra = {f_lvl, f_row[3:0], f_col};
		end else begin
			vd_ra  = {f_vid, is_start ? 3'd0 : d};
			ld_ra  = {f_lab, is_start ? 3'd0 : d};
			lp_ra  = {prev, f_lab};
			lpd_ra = {dm1, prev, f_lab};
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			path_limit_q <= dfsh_pkg::PATH_LIMIT_RESET;
		end else if (cfg_we) begin
			path_limit_q <= cfg_wdata;
		end
	end

	// Stack depth and sweep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			sweep_q <= '0;
		end else begin
			if (cmd.accept) begin
				if (is_start) level_q <= 4'd1;
				else if (is_disc && disc_ok) level_q <= level_q + 4'd1;
				else if (is_fin && fin_ok) level_q <= level_q - 4'd1;
			end
			if (cmd.sweep) sweep_q <= sweep_q + 1'b1;
		end
	end

	// Label stack entries; only read once written.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			if (is_start) stack_q[0] <= f_lab;
			else if (is_disc && disc_ok) stack_q[d] <= f_lab;
		end
	end

	// Item registers held for the execute step.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			inc_s1      <= is_start || (is_disc && disc_ok);
			pair_s1     <= is_disc && disc_ok;
			read_s1     <= is_read && read_ok;
			err_s1      <= err;
			clr_s1      <= is_clr;
			tab_s1      <= f_tab;
			vd_addr_s1  <= vd_ra;
			ld_addr_s1  <= ld_ra;
			lp_addr_s1  <= lp_ra;
			lpd_addr_s1 <= lpd_ra;
		end
	end

	// Count memories.
	logic [CB-1:0] vd_rd, ld_rd, lp_rd, lpd_rd;
	logic [CB-1:0] vd_wd, ld_wd, lp_wd, lpd_wd;
	logic          vd_we, ld_we, lp_we, lpd_we;
	logic [dfsh_pkg::VD_AW-1:0]  vd_wa;
	logic [dfsh_pkg::LD_AW-1:0]  ld_wa;
	logic [dfsh_pkg::LP_AW-1:0]  lp_wa;
	logic [dfsh_pkg::LPD_AW-1:0] lpd_wa;

	// Write side: zero sweep, or saturating increment in the execute step.
	always_comb begin
		if (cmd.sweep) begin
			vd_we  = 1'b1;
			ld_we  = sweep_q < 11'(dfsh_pkg::LD_DEPTH);
			lp_we  = sweep_q < 11'(dfsh_pkg::LP_DEPTH);
			lpd_we = sweep_q < 11'(dfsh_pkg::LPD_DEPTH);
			vd_wa  = sweep_q;
			ld_wa  = sweep_q[dfsh_pkg::LD_AW-1:0];
			lp_wa  = sweep_q[dfsh_pkg::LP_AW-1:0];
			lpd_wa = sweep_q;
			vd_wd  = '0;
			ld_wd  = '0;
			lp_wd  = '0;
			lpd_wd = '0;
		end else begin
			vd_we  = cmd.finish && inc_s1;
			ld_we  = cmd.finish && inc_s1;
			lp_we  = cmd.finish && pair_s1;
			lpd_we = cmd.finish && pair_s1;
			vd_wa  = vd_addr_s1;
			ld_wa  = ld_addr_s1;
			lp_wa  = lp_addr_s1;
			lpd_wa = lpd_addr_s1;
			vd_wd  = (vd_rd == COUNT_TOP) ? vd_rd : vd_rd + 1'b1;
			ld_wd  = (ld_rd == COUNT_TOP) ? ld_rd : ld_rd + 1'b1;
			lp_wd  = (lp_rd == COUNT_TOP) ? lp_rd : lp_rd + 1'b1;
			lpd_wd = (lpd_rd == COUNT_TOP) ? lpd_rd : lpd_rd + 1'b1;
		end
	end

	dfsh_ram #(.WIDTH(CB), .DEPTH(dfsh_pkg::VD_DEPTH), .AW(dfsh_pkg::VD_AW)) u_vd_ram (
		.clk(clk), .we(vd_we), .waddr(vd_wa), .wdata(vd_wd), .raddr(vd_ra), .rdata(vd_rd)
	);
	dfsh_ram #(.WIDTH(CB), .DEPTH(dfsh_pkg::LD_DEPTH), .AW(dfsh_pkg::LD_AW)) u_ld_ram (
		.clk(clk), .we(ld_we), .waddr(ld_wa), .wdata(ld_wd), .raddr(ld_ra), .rdata(ld_rd)
	);
	dfsh_ram #(.WIDTH(CB), .DEPTH(dfsh_pkg::LP_DEPTH), .AW(dfsh_pkg::LP_AW)) u_lp_ram (
		.clk(clk), .we(lp_we), .waddr(lp_wa), .wdata(lp_wd), .raddr(lp_ra), .rdata(lp_rd)
	);
	dfsh_ram #(.WIDTH(CB), .DEPTH(dfsh_pkg::LPD_DEPTH), .AW(dfsh_pkg::LPD_AW)) u_lpd_ram (
		.clk(clk), .we(lpd_we), .waddr(lpd_wa), .wdata(lpd_wd), .raddr(lpd_ra),
		.rdata(lpd_rd)
	);

	// Count selected for a read.
	logic [CB-1:0] read_count;
	always_comb begin
		unique case (tab_s1)
			dfsh_pkg::TAB_VERTEX_DEPTH: read_count = vd_rd;
			dfsh_pkg::TAB_LABEL_DEPTH:  read_count = ld_rd;
			dfsh_pkg::TAB_LABEL_PAIR:   read_count = lp_rd;
			dfsh_pkg::TAB_PAIR_DEPTH:   read_count = lpd_rd;
			default:                    read_count = '0;
		endcase
	end

	// Result word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			count_q <= read_s1 ? read_count : '0;
			error_q <= err_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = {7'd0, error_q, count_q};

	assign status.out_free   = !out_valid_q || out_ready;
	assign status.is_clear   = clr_s1;
	assign status.sweep_last = sweep_q == {dfsh_pkg::SWEEP_BITS{1'b1}};

	// The stack never holds more than the deepest path.
	assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= 4'(dfsh_pkg::DEPTH_LEVELS))
		else $error("stack level beyond maximum depth");

	// Every execute step leaves a result pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("result not registered");

	// Sweep and execute never share a cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.sweep && cmd.finish))
		else $error("sweep overlaps execute");

endmodule

>>> rtl/core/dfs_path_label_histogram_core.sv
// Depth-first path label histogram: controller plus datapath.
// Top level; depends on dfsh_pkg, dfsh_ctrl, dfsh_datapath and dfsh_ram.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one event or command word each. Every
//   accepted word yields exactly one result word on m_tvalid/m_tready/m_tdata,
//   in order. The path limit register is written through cfg_we/cfg_wdata;
//   the user must do so only while the core is idle; the core does not enforce it.
//   Each word goes through an accept step, which issues reads to the four count
//   memories, and an execute step for the saturating read-modify-write and
//   result registration; no new word is taken before that execute step is
//   done. m_tvalid is registered at the end of the execute step.
//   A clear command returns its result and then sweeps all four memories,
//   one address per cycle over all 2048 addresses, during which s_tready is low.
//   The same sweep runs after reset, which also empties the label stack and
//   loads a path limit of 4.
//   While m_tready is low the result is held; a new word is taken once the
//   pending result is being taken or gone.
`timescale 1ns / 1ps

module dfs_path_label_histogram_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// cmd[2:0], vertex_id[10:3], vertex_label[14:11], read_table[16:15],
	// read_row[24:17], read_col[28:25], read_level[31:29]
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// count[15:0], error[16], zero fill [23:17]
	output logic [23:0] m_tdata,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata
);

	dfsh_pkg::ctrl_cmd_t  cmd;
	dfsh_pkg::dp_status_t status;

	// Sequencing.
	dfsh_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.status(status), .cmd(cmd)
	);

	// Stack, tables and result.
	dfsh_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .in_word(s_tdata),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_word(m_tdata)
	);

endmodule
